// ----- rtl/core/nmea_gga_pkg.sv -----
// package: character codes, field indexes and result type of the gga field extractor
`timescale 1ns / 1ps

package nmea_gga_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_E      = 8'h45;

    localparam logic [2:0] HDR_LEN = 3'd6;

    localparam logic [3:0] FLD_TIME = 4'd1;
    localparam logic [3:0] FLD_LAT  = 4'd2;
    localparam logic [3:0] FLD_NS   = 4'd3;
    localparam logic [3:0] FLD_LON  = 4'd4;
    localparam logic [3:0] FLD_EW   = 4'd5;
    localparam logic [3:0] FLD_FIX  = 4'd6;
    localparam logic [3:0] FLD_SAT  = 4'd7;
    localparam logic [3:0] FLD_HDOP = 4'd8;
    localparam logic [3:0] FLD_ALT  = 4'd9;
    localparam logic [3:0] FLD_MAX  = 4'd15;

    typedef struct packed {
        logic [23:0] utc_time_bcd;
        logic [31:0] latitude_bcd;
        logic        is_north;
        logic [35:0] longitude_bcd;
        logic        is_east;
        logic [3:0]  fix_quality;
        logic [7:0]  satellites_bcd;
        logic [15:0] hdop_bcd;
        logic [23:0] altitude_bcd;
    } gga_result_t;

    // expected header character at a given match position ("$GPGGA")
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CHAR_DOLLAR;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/nmea_gga_field_extractor.sv -----
// top level: gga sentence parser with bcd field registers and a skid-buffered result port
//
//  channel | direction | ports                          | request
//  s_      | in        | s_valid, s_ready, s_rx_byte    | one received character
//  m_      | out       | m_valid, m_ready, m_* fields   | one parsed gga sentence
//
//  one character is taken per cycle while s_ready is high; the per-character update is one compare and shift
//  a line feed ending a matched sentence loads the registered result stage, or the skid stage while a result waits
//  synchronous active-low reset clears the parser and empties both result stages
//  a result stage and a skid stage let input continue while a result waits;
//  s_ready drops only while both hold a request
`timescale 1ns / 1ps

module nmea_gga_field_extractor
    import nmea_gga_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_utc_time_bcd,
    output logic [31:0] m_latitude_bcd,
    output logic        m_is_north,
    output logic [35:0] m_longitude_bcd,
    output logic        m_is_east,
    output logic [3:0]  m_fix_quality,
    output logic [7:0]  m_satellites_bcd,
    output logic [15:0] m_hdop_bcd,
    output logic [23:0] m_altitude_bcd
);

    logic [2:0]  header_pos_reg, header_pos_next;
    logic        match_reg, match_next;
    logic [3:0]  field_num_reg, field_num_next;
    logic        point_seen_reg, point_seen_next;
    gga_result_t fields_reg, fields_next;

    logic        m_valid_reg;
    gga_result_t out_reg;
    logic        skid_valid_reg;
    gga_result_t skid_reg;

    logic        in_fire;
    logic        emit;
    logic        is_digit;
    logic [3:0]  digit;
    logic        out_free;

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign is_digit = (s_rx_byte >= CHAR_ZERO) && (s_rx_byte <= CHAR_NINE);
    assign digit    = s_rx_byte[3:0];
    assign emit     = in_fire && (s_rx_byte == CHAR_LF) && match_reg;
    assign out_free = !m_valid_reg || m_ready;

    // parser next state
    always_comb begin
        header_pos_next = header_pos_reg;
        match_next      = match_reg;
        field_num_next  = field_num_reg;
        point_seen_next = point_seen_reg;
        fields_next     = fields_reg;
        if (s_rx_byte == CHAR_DOLLAR) begin
            header_pos_next = 3'd1;
            match_next      = 1'b0;
            field_num_next  = '0;
            point_seen_next = 1'b0;
            fields_next     = '0;
        end else if (s_rx_byte == CHAR_LF) begin
            header_pos_next = '0;
            match_next      = 1'b0;
        end else if (match_reg) begin
            if (s_rx_byte == CHAR_COMMA) begin
                if (field_num_reg != FLD_MAX) begin
                    field_num_next = field_num_reg + 4'd1;
                end
            end else begin
                case (field_num_reg)
                    FLD_TIME: begin
                        if (s_rx_byte == CHAR_POINT) begin
                            point_seen_next = 1'b1;
                        end else if (is_digit && !point_seen_reg) begin
                            fields_next.utc_time_bcd = {fields_reg.utc_time_bcd[19:0], digit};
                        end
                    end
                    FLD_LAT: begin
                        if (is_digit) begin
                            fields_next.latitude_bcd = {fields_reg.latitude_bcd[27:0], digit};
                        end
                    end
                    FLD_NS: fields_next.is_north = (s_rx_byte == CHAR_N);
                    FLD_LON: begin
                        if (is_digit) begin
                            fields_next.longitude_bcd = {fields_reg.longitude_bcd[31:0], digit};
                        end
                    end
                    FLD_EW: fields_next.is_east = (s_rx_byte == CHAR_E);
                    FLD_FIX: begin
                        if (is_digit) begin
                            fields_next.fix_quality = digit;
                        end
                    end
                    FLD_SAT: begin
                        if (is_digit) begin
                            fields_next.satellites_bcd = {fields_reg.satellites_bcd[3:0], digit};
                        end
                    end
                    FLD_HDOP: begin
                        if (is_digit) begin
                            fields_next.hdop_bcd = {fields_reg.hdop_bcd[11:0], digit};
                        end
                    end
                    FLD_ALT: begin
                        if (is_digit) begin
                            fields_next.altitude_bcd = {fields_reg.altitude_bcd[19:0], digit};
                        end
                    end
                    default: ;
                endcase
            end
        end else if (header_pos_reg >= 3'd1 && header_pos_reg < HDR_LEN) begin
            if (s_rx_byte == header_char(header_pos_reg)) begin
                header_pos_next = header_pos_reg + 3'd1;
                match_next      = (header_pos_reg + 3'd1) == HDR_LEN;
            end else begin
                header_pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pos_reg <= '0;
            match_reg      <= 1'b0;
            field_num_reg  <= '0;
            point_seen_reg <= 1'b0;
            fields_reg     <= '0;
        end else if (in_fire) begin
            header_pos_reg <= header_pos_next;
            match_reg      <= match_next;
            field_num_reg  <= field_num_next;
            point_seen_reg <= point_seen_next;
            fields_reg     <= fields_next;
        end
    end

    // result stage and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (emit) begin
            if (out_free) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (emit) begin
            if (out_free) begin
                out_reg <= fields_reg;
            end else begin
                skid_reg <= fields_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_utc_time_bcd   = out_reg.utc_time_bcd;
    assign m_latitude_bcd   = out_reg.latitude_bcd;
    assign m_is_north       = out_reg.is_north;
    assign m_longitude_bcd  = out_reg.longitude_bcd;
    assign m_is_east        = out_reg.is_east;
    assign m_fix_quality    = out_reg.fix_quality;
    assign m_satellites_bcd = out_reg.satellites_bcd;
    assign m_hdop_bcd       = out_reg.hdop_bcd;
    assign m_altitude_bcd   = out_reg.altitude_bcd;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid stage holds a request while result stage is empty");

    a_match_full_header: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg |-> (header_pos_reg == HDR_LEN))
        else $error("sentence flagged as matched without full header");

    a_emit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("line feed of matched sentence gave no result");

    a_dollar_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_rx_byte == CHAR_DOLLAR) |=>
            (header_pos_reg == 3'd1 && !match_reg && field_num_reg == 4'd0))
        else $error("dollar sign did not restart the parser");

endmodule

// ----- dv/nmea_gga_field_extractor_test.sv -----
// testbench: gga field extractor checked against an internal sentence predictor
`timescale 1ns / 1ps

module nmea_gga_field_extractor_test;
    import nmea_gga_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SENTENCE_GOAL = 1900;
    localparam int          DRAIN_CYCLES  = 20;
    localparam logic [47:0] GGA_TAG       = "$GPGGA";
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_MINUS    = 8'h2D;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_utc_time_bcd;
    logic [31:0] m_latitude_bcd;
    logic        m_is_north;
    logic [35:0] m_longitude_bcd;
    logic        m_is_east;
    logic [3:0]  m_fix_quality;
    logic [7:0]  m_satellites_bcd;
    logic [15:0] m_hdop_bcd;
    logic [23:0] m_altitude_bcd;

    // sentence predictor state
    logic [2:0]  hdr_pos = 3'd0;
    logic        in_gga = 1'b0;
    logic [3:0]  field_idx = 4'd0;
    logic        time_frac = 1'b0;
    gga_result_t fix_acc = '0;
    gga_result_t pending_fixes[$];

    logic [7:0]  line_buf[$];
    logic        idle_on = 1'b1;
    logic        rx_hold = 1'b0;
    event        hold_start;
    int          mismatch_count = 0;
    int          sentence_bytes = 0;
    int          cycle_count;

    nmea_gga_field_extractor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_utc_time_bcd  (m_utc_time_bcd),
        .m_latitude_bcd  (m_latitude_bcd),
        .m_is_north      (m_is_north),
        .m_longitude_bcd (m_longitude_bcd),
        .m_is_east       (m_is_east),
        .m_fix_quality   (m_fix_quality),
        .m_satellites_bcd(m_satellites_bcd),
        .m_hdop_bcd      (m_hdop_bcd),
        .m_altitude_bcd  (m_altitude_bcd)
    );

    always #10 aclk = ~aclk;

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic track_char(input logic [7:0] ch);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        d = ch[3:0];
        if (ch == CHAR_DOLLAR) begin
            hdr_pos = 3'd1;
            in_gga = 1'b0;
            field_idx = 4'd0;
            time_frac = 1'b0;
            fix_acc = '0;
        end else if (ch == CHAR_LF) begin
            if (in_gga) begin
                pending_fixes.push_back(fix_acc);
            end
            hdr_pos = 3'd0;
            in_gga = 1'b0;
        end else if (in_gga) begin
            if (ch == CHAR_COMMA) begin
                if (field_idx != FLD_MAX) begin
                    field_idx++;
                end
            end else begin
                case (field_idx)
                    FLD_TIME: begin
                        if (ch == CHAR_POINT) begin
                            time_frac = 1'b1;
                        end else if (is_digit && !time_frac) begin
                            fix_acc.utc_time_bcd = {fix_acc.utc_time_bcd[19:0], d};
                        end
                    end
                    FLD_LAT: begin
                        if (is_digit) fix_acc.latitude_bcd = {fix_acc.latitude_bcd[27:0], d};
                    end
                    FLD_NS: fix_acc.is_north = (ch == CHAR_N);
                    FLD_LON: begin
                        if (is_digit) fix_acc.longitude_bcd = {fix_acc.longitude_bcd[31:0], d};
                    end
                    FLD_EW: fix_acc.is_east = (ch == CHAR_E);
                    FLD_FIX: begin
                        if (is_digit) fix_acc.fix_quality = d;
                    end
                    FLD_SAT: begin
                        if (is_digit) fix_acc.satellites_bcd = {fix_acc.satellites_bcd[3:0], d};
                    end
                    FLD_HDOP: begin
                        if (is_digit) fix_acc.hdop_bcd = {fix_acc.hdop_bcd[11:0], d};
                    end
                    FLD_ALT: begin
                        if (is_digit) fix_acc.altitude_bcd = {fix_acc.altitude_bcd[19:0], d};
                    end
                    default: ;
                endcase
            end
        end else if (hdr_pos >= 3'd1 && hdr_pos < HDR_LEN) begin
            if (ch == GGA_TAG[47 - 8 * int'(hdr_pos) -: 8]) begin
                hdr_pos++;
                if (hdr_pos == HDR_LEN) in_gga = 1'b1;
            end else begin
                hdr_pos = 3'd0;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] ch);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= ch;
        do @(posedge aclk); while (!s_ready);
        track_char(ch);
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
    endtask

    task automatic send_line();
        while (line_buf.size() != 0) begin
            sentence_bytes++;
            send_byte(line_buf.pop_front());
        end
    endtask

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CHAR_DOLLAR || c == CHAR_COMMA);
        return c;
    endfunction

    task automatic put_number(input int maxlen);
        int n;
        int r;
        n = $urandom_range(0, maxlen);
        repeat (n) begin
            r = $urandom_range(0, 23);
            if (r < 18) line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            else if (r < 20) line_buf.push_back(CHAR_POINT);
            else if (r == 20) line_buf.push_back(CHAR_MINUS);
            else line_buf.push_back(junk_char());
        end
    endtask

    task automatic put_hemisphere();
        string letters;
        letters = "NSEWnx";
        repeat ($urandom_range(0, 2)) line_buf.push_back(letters[$urandom_range(0, 5)]);
    endtask

    task automatic put_gga_sentence();
        put_text("$GPGGA,");
        put_number(10);
        put_text(",");
        put_number(12);
        put_text(",");
        put_hemisphere();
        put_text(",");
        put_number(12);
        put_text(",");
        put_hemisphere();
        put_text(",");
        put_number(2);
        put_text(",");
        put_number(3);
        put_text(",");
        put_number(6);
        put_text(",");
        put_number(9);
        case ($urandom_range(0, 3))
            1: put_text(",M,46.9,M,,*47");
            2: begin
                repeat ($urandom_range(1, 8)) begin
                    put_text(",");
                    put_number(3);
                end
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
    endtask

    task automatic test_reference_sentence();
        put_text("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        put_text("$GPGGA,999999.99,99999999,N,999999999,E,9,99,99.99,9999.99\n");
        send_line();
    endtask

    task automatic test_field_corners();
        // empty fields, overlong fields, last hemisphere letter wins, odd bytes
        put_text("$GPGGA,,,,,,,,,,,,,,*56\r\n");
        put_text("$GPGGA,12345678.9,1234567890,SN,12345678901,WE,123,456,12.345,-12345.678\n");
        put_text("$GPGGA,1a2");
        line_buf.push_back(8'h00);
        put_text("3,5,Nx,7,Ey,");
        line_buf.push_back(8'hFF);
        put_text("4,0.,.7,1.2.3\n");
        send_line();
    endtask

    task automatic test_line_framing();
        put_text("$GPRMC,1,2\n$GPGGX,1,2\n$GPG$GPGGA,7\nabc,12\n");
        put_text("$GPGGA,1\n\n$GPGGA,11$GPGGA,22\n$GPGGA,33,44");
        put_text("$GPGGA,55,66,N\n$GPGGA,,,,,,,,,,,,,,,,,,9\n$GPGGA");
        line_buf.push_back(CHAR_LF);
        send_line();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        -> hold_start;
        for (int i = 0; i < 6; i++) begin
            put_text($sformatf("$GPGGA,%0d,%0d\n", i, 9 - i));
            send_line();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int pick;
        int pos;
        while (sentence_bytes < SENTENCE_GOAL) begin
            if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                put_gga_sentence();
                send_line();
            end else if (pick == 8) begin
                put_gga_sentence();
                case ($urandom_range(0, 3))
                    0: begin
                        pos = $urandom_range(1, 5);
                        line_buf[pos] = 8'($urandom_range(8'h41, 8'h5A));
                    end
                    1: void'(line_buf.pop_back());
                    2: line_buf[$urandom_range(1, line_buf.size() - 1)] = CHAR_DOLLAR;
                    default: line_buf[$urandom_range(0, line_buf.size() - 1)] = CHAR_LF;
                endcase
                send_line();
            end else begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // result side
    initial begin
        gga_result_t got;
        gga_result_t want;
        int          stall;
        wait (aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0 || rx_hold) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_utc_time_bcd, m_latitude_bcd, m_is_north, m_longitude_bcd, m_is_east,
                    m_fix_quality, m_satellites_bcd, m_hdop_bcd, m_altitude_bcd};
            if (pending_fixes.size() == 0) begin
                report("result with no sentence pending");
            end else begin
                want = pending_fixes.pop_front();
                check_field("utc_time", 64'(got.utc_time_bcd), 64'(want.utc_time_bcd));
                check_field("latitude", 64'(got.latitude_bcd), 64'(want.latitude_bcd));
                check_field("is_north", 64'(got.is_north), 64'(want.is_north));
                check_field("longitude", 64'(got.longitude_bcd), 64'(want.longitude_bcd));
                check_field("is_east", 64'(got.is_east), 64'(want.is_east));
                check_field("fix_quality", 64'(got.fix_quality), 64'(want.fix_quality));
                check_field("satellites", 64'(got.satellites_bcd),
                            64'(want.satellites_bcd));
                check_field("hdop", 64'(got.hdop_bcd), 64'(want.hdop_bcd));
                check_field("altitude", 64'(got.altitude_bcd), 64'(want.altitude_bcd));
            end
        end
    end

    // long receiver hold
    initial begin
        @(hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("nmea_gga_field_extractor_test failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reference_sentence();
        test_field_corners();
        test_line_framing();
        test_backpressure();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("nmea_gga_field_extractor_test passed");
        end else begin
            $display("nmea_gga_field_extractor_test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/nmea_gga_pkg.sv
rtl/core/nmea_gga_field_extractor.sv
dv/nmea_gga_field_extractor_test.sv
